### sv/kpl_pkg.sv
// Shared types, codes and constants of the keypad password lock.
`default_nettype none
package kpl_pkg;

  // Table geometry, fixed by the result field widths.
  localparam int MAX_PASSWORDS   = 6;
  localparam int PASSWORD_LENGTH = 4;
  localparam int BYTE_W          = 8;
  localparam int VAL_W           = 32;
  localparam int IDX_W           = 3;   // table slot index
  localparam int CNT_W           = 3;   // table fill count, 0..MAX_PASSWORDS
  localparam int LEN_W           = 3;   // entry buffer fill, 0..PASSWORD_LENGTH
  localparam int BUF_IW          = 2;   // entry buffer index
  localparam int EV_W            = 4;
  localparam int MODE_W          = 3;
  localparam int UPC_W           = 6;

  // Key codes.
  localparam logic [BYTE_W-1:0] KEY_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] KEY_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] KEY_0    = 8'h30;
  localparam logic [BYTE_W-1:0] KEY_1    = 8'h31;
  localparam logic [BYTE_W-1:0] KEY_2    = 8'h32;
  localparam logic [BYTE_W-1:0] KEY_3    = 8'h33;
  localparam logic [BYTE_W-1:0] KEY_4    = 8'h34;
  localparam logic [VAL_W-1:0]  DASH_VAL = 32'h0000_002D;

  // Operating modes.
  localparam logic [MODE_W-1:0] MODE_LOCKED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MENU   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd4;

  // Result events.
  localparam logic [EV_W-1:0] EV_IGNORED    = 4'd0;
  localparam logic [EV_W-1:0] EV_DIGIT      = 4'd1;
  localparam logic [EV_W-1:0] EV_ERASED     = 4'd2;
  localparam logic [EV_W-1:0] EV_UNLOCKED   = 4'd3;
  localparam logic [EV_W-1:0] EV_REJECTED   = 4'd4;
  localparam logic [EV_W-1:0] EV_SLOT       = 4'd5;
  localparam logic [EV_W-1:0] EV_CHANGED    = 4'd6;
  localparam logic [EV_W-1:0] EV_ADDED      = 4'd7;
  localparam logic [EV_W-1:0] EV_FULL       = 4'd8;
  localparam logic [EV_W-1:0] EV_SHOWN      = 4'd9;
  localparam logic [EV_W-1:0] EV_EMPTY      = 4'd10;
  localparam logic [EV_W-1:0] EV_LOCKED     = 4'd11;
  localparam logic [EV_W-1:0] EV_MENU       = 4'd12;
  localparam logic [EV_W-1:0] EV_AWAIT_SLOT = 4'd13;
  localparam logic [EV_W-1:0] EV_AWAIT_NEW  = 4'd14;
  localparam logic [EV_W-1:0] EV_LOADED     = 4'd15;

  // Datapath operations.
  localparam logic [3:0] OP_NONE        = 4'd0;
  localparam logic [3:0] OP_APPEND_LOAD = 4'd1;
  localparam logic [3:0] OP_PUSH        = 4'd2;
  localparam logic [3:0] OP_POP         = 4'd3;
  localparam logic [3:0] OP_IDX_CLR     = 4'd4;
  localparam logic [3:0] OP_IDX_INC     = 4'd5;
  localparam logic [3:0] OP_CNT_CLR     = 4'd6;
  localparam logic [3:0] OP_SLOT_SET    = 4'd7;
  localparam logic [3:0] OP_WR_SLOT     = 4'd8;
  localparam logic [3:0] OP_CMT_CLR     = 4'd9;
  localparam logic [3:0] OP_APPEND_BUF  = 4'd10;

  // Jump conditions.
  localparam logic [3:0] C_NEXT     = 4'd0;
  localparam logic [3:0] C_ALWAYS   = 4'd1;
  localparam logic [3:0] C_NO_INPUT = 4'd2;
  localparam logic [3:0] C_DISPATCH = 4'd3;
  localparam logic [3:0] C_TBL_FULL = 4'd4;
  localparam logic [3:0] C_IDX_END  = 4'd5;
  localparam logic [3:0] C_MATCH    = 4'd6;
  localparam logic [3:0] C_TBL_EMPTY = 4'd7;
  localparam logic [3:0] C_IDX_LAST = 4'd8;

  // Result value sources.
  localparam logic [1:0] VS_ZERO = 2'd0;
  localparam logic [1:0] VS_BUF  = 2'd1;
  localparam logic [1:0] VS_TBL  = 2'd2;
  localparam logic [1:0] VS_DASH = 2'd3;

  // One control word of the microprogram.
  typedef struct packed {
    logic [3:0]        op;
    logic              set_mode;
    logic [MODE_W-1:0] mode_val;
    logic              emit;
    logic [EV_W-1:0]   ev;
    logic [1:0]        vsrc;
    logic              slot_idx;   // shown_slot from walk index
    logic              last_idx;   // last flag only on final table entry
    logic [3:0]        cond;
    logic [UPC_W-1:0]  tgt;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic              in_acc;
    logic              adv;
    logic [3:0]        op;
    logic              set_mode;
    logic [MODE_W-1:0] mode_val;
    logic [EV_W-1:0]   ev;
    logic [1:0]        vsrc;
    logic              slot_idx;
    logic              last;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] key;
    logic [MODE_W-1:0] mode;
    logic              ent_full;
    logic              ent_zero;
    logic              tbl_full;
    logic              tbl_empty;
    logic              idx_end;
    logic              idx_last;
    logic              match;
  } stat_t;

  // One result beat.
  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [LEN_W-1:0]  len;
    logic              unl;
    logic [CNT_W-1:0]  stored;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  slot;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

### sv/kpl_seq.sv
// Microprogram ROM, step counter and jump logic of the keypad lock.
`default_nettype none
module kpl_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            out_busy,
  input  wire kpl_pkg::stat_t  st,
  output logic                 in_ready,
  output logic                 emit_go,
  output kpl_pkg::ctrl_t       ctrl
);

  // Step addresses.
  localparam logic [kpl_pkg::UPC_W-1:0] A_IDLE     = 6'd0;
  localparam logic [kpl_pkg::UPC_W-1:0] A_PRE      = 6'd2;
  localparam logic [kpl_pkg::UPC_W-1:0] A_FULL     = 6'd5;
  localparam logic [kpl_pkg::UPC_W-1:0] A_DIGIT    = 6'd6;
  localparam logic [kpl_pkg::UPC_W-1:0] A_ERASE    = 6'd8;
  localparam logic [kpl_pkg::UPC_W-1:0] A_IGN      = 6'd10;
  localparam logic [kpl_pkg::UPC_W-1:0] A_LK_CMT   = 6'd11;
  localparam logic [kpl_pkg::UPC_W-1:0] A_LK_WALK  = 6'd12;
  localparam logic [kpl_pkg::UPC_W-1:0] A_LK_REJ   = 6'd15;
  localparam logic [kpl_pkg::UPC_W-1:0] A_LK_OK    = 6'd17;
  localparam logic [kpl_pkg::UPC_W-1:0] A_M1       = 6'd19;
  localparam logic [kpl_pkg::UPC_W-1:0] A_M2       = 6'd21;
  localparam logic [kpl_pkg::UPC_W-1:0] A_M2_SHOW  = 6'd22;
  localparam logic [kpl_pkg::UPC_W-1:0] A_M2_EMPTY = 6'd24;
  localparam logic [kpl_pkg::UPC_W-1:0] A_M3       = 6'd25;
  localparam logic [kpl_pkg::UPC_W-1:0] A_M4       = 6'd28;
  localparam logic [kpl_pkg::UPC_W-1:0] A_MX       = 6'd30;
  localparam logic [kpl_pkg::UPC_W-1:0] A_SLOT     = 6'd31;
  localparam logic [kpl_pkg::UPC_W-1:0] A_CH_CMT   = 6'd33;
  localparam logic [kpl_pkg::UPC_W-1:0] A_AD_CMT   = 6'd36;
  localparam logic [kpl_pkg::UPC_W-1:0] A_AD_FULL  = 6'd39;

  logic [kpl_pkg::UPC_W-1:0] upc_r, upc_nxt;
  kpl_pkg::uword_t           uw;
  logic [kpl_pkg::UPC_W-1:0] disp_tgt;
  logic [kpl_pkg::UPC_W-1:0] commit_tgt;
  logic                      take;
  logic                      stall;
  logic                      is_digit;

  // Build one control word.
  function automatic kpl_pkg::uword_t mk(
    input logic [3:0]                 op,
    input logic                       sm,
    input logic [kpl_pkg::MODE_W-1:0] mv,
    input logic                       em,
    input logic [kpl_pkg::EV_W-1:0]   ev,
    input logic [1:0]                 vs,
    input logic                       si,
    input logic                       li,
    input logic [3:0]                 cond,
    input logic [kpl_pkg::UPC_W-1:0]  tgt
  );
    kpl_pkg::uword_t w;
    w.op       = op;
    w.set_mode = sm;
    w.mode_val = mv;
    w.emit     = em;
    w.ev       = ev;
    w.vsrc     = vs;
    w.slot_idx = si;
    w.last_idx = li;
    w.cond     = cond;
    w.tgt      = tgt;
    return w;
  endfunction

  // Emit a single closing result and return to idle.
  function automatic kpl_pkg::uword_t emit_end(
    input logic [kpl_pkg::EV_W-1:0] ev,
    input logic [1:0]               vs
  );
    return mk(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED, 1'b1, ev, vs, 1'b0, 1'b0,
              kpl_pkg::C_ALWAYS, A_IDLE);
  endfunction

  // Plain step: datapath op, optional mode write, then jump.
  function automatic kpl_pkg::uword_t op_step(
    input logic [3:0]                 op,
    input logic                       sm,
    input logic [kpl_pkg::MODE_W-1:0] mv,
    input logic [3:0]                 cond,
    input logic [kpl_pkg::UPC_W-1:0]  tgt
  );
    return mk(op, sm, mv, 1'b0, kpl_pkg::EV_IGNORED, kpl_pkg::VS_ZERO, 1'b0, 1'b0,
              cond, tgt);
  endfunction

  // Microprogram.
  always_comb begin
    unique case (upc_r)
      6'd0:  uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NO_INPUT, A_IDLE);
      6'd1:  uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_DISPATCH, A_IDLE);
      // preload
      6'd2:  uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_TBL_FULL, A_FULL);
      6'd3:  uw = op_step(kpl_pkg::OP_APPEND_LOAD, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd4:  uw = emit_end(kpl_pkg::EV_LOADED, kpl_pkg::VS_ZERO);
      6'd5:  uw = emit_end(kpl_pkg::EV_FULL, kpl_pkg::VS_ZERO);
      // buffer edits
      6'd6:  uw = op_step(kpl_pkg::OP_PUSH, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd7:  uw = emit_end(kpl_pkg::EV_DIGIT, kpl_pkg::VS_ZERO);
      6'd8:  uw = op_step(kpl_pkg::OP_POP, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd9:  uw = emit_end(kpl_pkg::EV_ERASED, kpl_pkg::VS_ZERO);
      6'd10: uw = emit_end(kpl_pkg::EV_IGNORED, kpl_pkg::VS_ZERO);
      // password check: walk the table
      6'd11: uw = op_step(kpl_pkg::OP_IDX_CLR, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd12: uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_IDX_END, A_LK_REJ);
      6'd13: uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_MATCH, A_LK_OK);
      6'd14: uw = op_step(kpl_pkg::OP_IDX_INC, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_ALWAYS, A_LK_WALK);
      6'd15: uw = op_step(kpl_pkg::OP_CNT_CLR, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd16: uw = emit_end(kpl_pkg::EV_REJECTED, kpl_pkg::VS_ZERO);
      6'd17: uw = op_step(kpl_pkg::OP_CNT_CLR, 1'b1, kpl_pkg::MODE_MENU,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd18: uw = emit_end(kpl_pkg::EV_UNLOCKED, kpl_pkg::VS_BUF);
      // menu '1'
      6'd19: uw = op_step(kpl_pkg::OP_NONE, 1'b1, kpl_pkg::MODE_SLOT,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd20: uw = emit_end(kpl_pkg::EV_AWAIT_SLOT, kpl_pkg::VS_ZERO);
      // menu '2': one beat per stored entry
      6'd21: uw = op_step(kpl_pkg::OP_IDX_CLR, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_TBL_EMPTY, A_M2_EMPTY);
      6'd22: uw = mk(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED, 1'b1,
                     kpl_pkg::EV_SHOWN, kpl_pkg::VS_TBL, 1'b1, 1'b1,
                     kpl_pkg::C_IDX_LAST, A_IDLE);
      6'd23: uw = op_step(kpl_pkg::OP_IDX_INC, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_ALWAYS, A_M2_SHOW);
      6'd24: uw = emit_end(kpl_pkg::EV_EMPTY, kpl_pkg::VS_ZERO);
      // menu '3'
      6'd25: uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_TBL_FULL, A_FULL);
      6'd26: uw = op_step(kpl_pkg::OP_CNT_CLR, 1'b1, kpl_pkg::MODE_ADD,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd27: uw = emit_end(kpl_pkg::EV_AWAIT_NEW, kpl_pkg::VS_ZERO);
      // menu '4'
      6'd28: uw = op_step(kpl_pkg::OP_CNT_CLR, 1'b1, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd29: uw = emit_end(kpl_pkg::EV_LOCKED, kpl_pkg::VS_DASH);
      // other menu keys
      6'd30: uw = emit_end(kpl_pkg::EV_MENU, kpl_pkg::VS_ZERO);
      // slot choice
      6'd31: uw = op_step(kpl_pkg::OP_SLOT_SET, 1'b1, kpl_pkg::MODE_CHANGE,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd32: uw = emit_end(kpl_pkg::EV_SLOT, kpl_pkg::VS_ZERO);
      // change commit
      6'd33: uw = op_step(kpl_pkg::OP_WR_SLOT, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd34: uw = op_step(kpl_pkg::OP_CMT_CLR, 1'b1, kpl_pkg::MODE_MENU,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd35: uw = emit_end(kpl_pkg::EV_CHANGED, kpl_pkg::VS_ZERO);
      // add commit
      6'd36: uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                          kpl_pkg::C_TBL_FULL, A_AD_FULL);
      6'd37: uw = op_step(kpl_pkg::OP_APPEND_BUF, 1'b1, kpl_pkg::MODE_MENU,
                          kpl_pkg::C_NEXT, A_IDLE);
      6'd38: uw = emit_end(kpl_pkg::EV_ADDED, kpl_pkg::VS_ZERO);
      6'd39: uw = op_step(kpl_pkg::OP_CNT_CLR, 1'b1, kpl_pkg::MODE_MENU,
                          kpl_pkg::C_ALWAYS, A_FULL);
      default: uw = op_step(kpl_pkg::OP_NONE, 1'b0, kpl_pkg::MODE_LOCKED,
                            kpl_pkg::C_ALWAYS, A_IDLE);
    endcase
  end

  // Dispatch on the latched beat.
  assign is_digit = !st.ent_full && st.key != kpl_pkg::KEY_STAR &&
                    st.key != kpl_pkg::KEY_HASH;

  always_comb begin
    unique case (st.mode)
      kpl_pkg::MODE_CHANGE: commit_tgt = A_CH_CMT;
      kpl_pkg::MODE_ADD:    commit_tgt = A_AD_CMT;
      default:              commit_tgt = A_LK_CMT;
    endcase
  end

  always_comb begin
    if (st.kind) begin
      disp_tgt = A_PRE;
    end else begin
      unique case (st.mode) inside
        kpl_pkg::MODE_LOCKED, kpl_pkg::MODE_CHANGE, kpl_pkg::MODE_ADD: begin
          if (is_digit) begin
            disp_tgt = A_DIGIT;
          end else if (!st.ent_zero && st.key == kpl_pkg::KEY_HASH) begin
            disp_tgt = A_ERASE;
          end else if (st.ent_full && st.key == kpl_pkg::KEY_STAR) begin
            disp_tgt = commit_tgt;
          end else begin
            disp_tgt = A_IGN;
          end
        end
        kpl_pkg::MODE_MENU: begin
          unique case (st.key)
            kpl_pkg::KEY_1: disp_tgt = A_M1;
            kpl_pkg::KEY_2: disp_tgt = A_M2;
            kpl_pkg::KEY_3: disp_tgt = A_M3;
            kpl_pkg::KEY_4: disp_tgt = A_M4;
            default:        disp_tgt = A_MX;
          endcase
        end
        kpl_pkg::MODE_SLOT: disp_tgt = A_SLOT;
        default:            disp_tgt = A_IGN;
      endcase
    end
  end

  always_comb begin
    unique case (uw.cond)
      kpl_pkg::C_NEXT:      take = 1'b0;
      kpl_pkg::C_ALWAYS:    take = 1'b1;
      kpl_pkg::C_NO_INPUT:  take = !in_valid;
      kpl_pkg::C_DISPATCH:  take = 1'b1;
      kpl_pkg::C_TBL_FULL:  take = st.tbl_full;
      kpl_pkg::C_IDX_END:   take = st.idx_end;
      kpl_pkg::C_MATCH:     take = st.match;
      kpl_pkg::C_TBL_EMPTY: take = st.tbl_empty;
      kpl_pkg::C_IDX_LAST:  take = st.idx_last;
      default:              take = 1'b1;
    endcase
  end

  // An emitting step holds while the result register is still full.
  assign stall    = uw.emit && out_busy;
  assign emit_go  = uw.emit && !out_busy;
  assign in_ready = (upc_r == A_IDLE);

  always_comb begin
    if (stall) begin
      upc_nxt = upc_r;
    end else if (take) begin
      upc_nxt = (uw.cond == kpl_pkg::C_DISPATCH) ? disp_tgt : uw.tgt;
    end else begin
      upc_nxt = upc_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= A_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    ctrl.in_acc   = in_ready && in_valid;
    ctrl.adv      = !stall;
    ctrl.op       = uw.op;
    ctrl.set_mode = uw.set_mode;
    ctrl.mode_val = uw.mode_val;
    ctrl.ev       = uw.ev;
    ctrl.vsrc     = uw.vsrc;
    ctrl.slot_idx = uw.slot_idx;
    ctrl.last     = !uw.last_idx || st.idx_last;
  end

endmodule
`default_nettype wire

### sv/kpl_dp.sv
// Datapath of the keypad lock: latched beat, entry buffer, password table.
`default_nettype none
module kpl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_kind,
  input  wire logic [kpl_pkg::BYTE_W-1:0]  in_key,
  input  wire logic [kpl_pkg::VAL_W-1:0]   in_load,
  input  wire kpl_pkg::ctrl_t              ctrl,
  output kpl_pkg::stat_t                   st,
  output kpl_pkg::res_t                    res
);

  logic                        kind_r;
  logic [kpl_pkg::BYTE_W-1:0]  key_r;
  logic [kpl_pkg::VAL_W-1:0]   load_r;
  logic [kpl_pkg::MODE_W-1:0]  mode_r;
  logic [kpl_pkg::LEN_W-1:0]   cnt_r;
  logic [kpl_pkg::BYTE_W-1:0]  tgt_r;
  logic [kpl_pkg::CNT_W-1:0]   tcnt_r;
  logic [kpl_pkg::IDX_W-1:0]   idx_r;
  logic [kpl_pkg::BYTE_W-1:0]  buf_r [kpl_pkg::PASSWORD_LENGTH];
  logic [kpl_pkg::VAL_W-1:0]   tbl_r [kpl_pkg::MAX_PASSWORDS];

  logic [kpl_pkg::VAL_W-1:0]   packed_buf;
  logic [kpl_pkg::VAL_W-1:0]   tbl_rd;
  logic [kpl_pkg::BYTE_W-1:0]  slot_off;
  logic [kpl_pkg::IDX_W-1:0]   idx_inc;

  // First digit lands in the top byte.
  always_comb begin
    packed_buf = '0;
    for (int i = 0; i < kpl_pkg::PASSWORD_LENGTH; i++) begin
      packed_buf[(kpl_pkg::PASSWORD_LENGTH-1-i)*kpl_pkg::BYTE_W +: kpl_pkg::BYTE_W] = buf_r[i];
    end
  end

  assign tbl_rd   = tbl_r[idx_r];
  assign slot_off = tgt_r - kpl_pkg::KEY_0;
  assign idx_inc  = idx_r + 3'd1;

  always_comb begin
    st.kind      = kind_r;
    st.key       = key_r;
    st.mode      = mode_r;
    st.ent_full  = (cnt_r == kpl_pkg::LEN_W'(kpl_pkg::PASSWORD_LENGTH));
    st.ent_zero  = (cnt_r == '0);
    st.tbl_full  = (tcnt_r >= kpl_pkg::CNT_W'(kpl_pkg::MAX_PASSWORDS));
    st.tbl_empty = (tcnt_r == '0);
    st.idx_end   = (idx_r >= tcnt_r);
    st.idx_last  = (idx_inc >= tcnt_r);
    st.match     = (tbl_rd == packed_buf);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= kpl_pkg::MODE_LOCKED;
      cnt_r  <= '0;
      tgt_r  <= '0;
      tcnt_r <= '0;
      idx_r  <= '0;
    end else if (ctrl.adv) begin
      if (ctrl.set_mode) begin
        mode_r <= ctrl.mode_val;
      end
      unique case (ctrl.op)
        kpl_pkg::OP_NONE:        ;
        kpl_pkg::OP_APPEND_LOAD: tcnt_r <= tcnt_r + 3'd1;
        kpl_pkg::OP_PUSH:        cnt_r <= cnt_r + 3'd1;
        kpl_pkg::OP_POP:         cnt_r <= cnt_r - 3'd1;
        kpl_pkg::OP_IDX_CLR:     idx_r <= '0;
        kpl_pkg::OP_IDX_INC:     idx_r <= idx_inc;
        kpl_pkg::OP_CNT_CLR:     cnt_r <= '0;
        kpl_pkg::OP_SLOT_SET: begin
          tgt_r <= key_r;
          cnt_r <= '0;
        end
        kpl_pkg::OP_WR_SLOT:     ;
        kpl_pkg::OP_CMT_CLR: begin
          cnt_r <= '0;
          tgt_r <= '0;
        end
        kpl_pkg::OP_APPEND_BUF: begin
          tcnt_r <= tcnt_r + 3'd1;
          cnt_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload: latched beat, buffer and table.
  always_ff @(posedge clk) begin
    if (ctrl.in_acc) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      load_r <= in_load;
    end
    if (ctrl.adv) begin
      unique case (ctrl.op)
        kpl_pkg::OP_PUSH:        buf_r[cnt_r[kpl_pkg::BUF_IW-1:0]] <= key_r;
        kpl_pkg::OP_APPEND_LOAD: tbl_r[tcnt_r] <= load_r;
        kpl_pkg::OP_APPEND_BUF:  tbl_r[tcnt_r] <= packed_buf;
        kpl_pkg::OP_WR_SLOT: begin
          // out-of-range slot leaves the table alone
          if (slot_off < kpl_pkg::BYTE_W'(tcnt_r)) begin
            tbl_r[slot_off[kpl_pkg::IDX_W-1:0]] <= packed_buf;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.ev     = ctrl.ev;
    res.len    = cnt_r;
    res.unl    = (mode_r != kpl_pkg::MODE_LOCKED);
    res.stored = tcnt_r;
    res.slot   = ctrl.slot_idx ? idx_r : '0;
    res.last   = ctrl.last;
    unique case (ctrl.vsrc)
      kpl_pkg::VS_BUF:  res.value = packed_buf;
      kpl_pkg::VS_TBL:  res.value = tbl_rd;
      kpl_pkg::VS_DASH: res.value = kpl_pkg::DASH_VAL;
      default:          res.value = '0;
    endcase
  end

endmodule
`default_nettype wire

### sv/keypad_password_lock.sv
// Keypad password lock: microcoded sequencer, datapath and result register.
// Beats are taken one at a time: the next is accepted only once the sequencer is back in idle
// after the last result of the previous beat. A check walks the stored entries in order;
// a show run gives one result per stored entry. Output stalls hold every emitting step.
// Reset (rst_n low, synchronous): mode locked, counts zero, sequencer idle, no result.
`default_nettype none
module keypad_password_lock (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beats
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] key_code, [39:8] load_value
  input  wire logic        in_tuser,   // [0] kind: 0 key press, 1 preload
  // result beats
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [3:0] event_res, [6:4] entry_length,
                                       // [7] unlocked, [10:8] stored_count,
                                       // [42:11] entry_value, [45:43] shown_slot,
                                       // [47:46] zero
  output logic             out_tlast   // last result of the input beat
);

  kpl_pkg::ctrl_t ctrl;
  kpl_pkg::stat_t st;
  kpl_pkg::res_t  res;
  kpl_pkg::res_t  res_r;
  logic           out_valid_r;
  logic           out_busy;
  logic           emit_go;

  // Result register: the sequencer holds an emitting step while it is full.
  assign out_busy = out_valid_r && !out_tready;

  kpl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .st       (st),
    .in_ready (in_tready),
    .emit_go  (emit_go),
    .ctrl     (ctrl)
  );

  kpl_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_kind (in_tuser),
    .in_key  (in_tdata[7:0]),
    .in_load (in_tdata[39:8]),
    .ctrl    (ctrl),
    .st      (st),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {2'b00, res_r.slot, res_r.value, res_r.stored, res_r.unl,
                       res_r.len, res_r.ev};

endmodule
`default_nettype wire
